// ----- hdl/tabular_page_extractor_core_assert.svh -----
// -----------------------------------------------------------------------------
// Tabular page extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// -----------------------------------------------------------------------------
`ifndef TABULAR_PAGE_EXTRACTOR_CORE_ASSERT_SVH
`define TABULAR_PAGE_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define TPE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TPE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tpe_pkg.sv -----
// -----------------------------------------------------------------------------
// Tabular page extractor package
// Shared types, result codes and constants of the page extractor.
// -----------------------------------------------------------------------------
package tpe_pkg;

	localparam int MAX_LINES_DEF      = 17;
	localparam int MAX_LINE_CHARS_DEF = 80;

	localparam int SKIP_BYTES = 126;
	localparam int BLOCK_ID   = 3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic REG_STANDALONE  = 1'b0;
	localparam logic REG_WANTED_PAGE = 1'b1;

	localparam logic [2:0] K_CHAR       = 3'd0;
	localparam logic [2:0] K_LINE_END   = 3'd1;
	localparam logic [2:0] K_DONE       = 3'd2;
	localparam logic [2:0] K_BAD_HEADER = 3'd3;
	localparam logic [2:0] K_TOO_LONG   = 3'd4;
	localparam logic [2:0] K_TOO_MANY   = 3'd5;
	localparam logic [2:0] K_BAD_LENGTH = 3'd6;

	typedef struct packed {
		logic        standalone_mode;
		logic [14:0] wanted_page;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_byte;
		logic [14:0] page_total;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_t;

endpackage

// ----- hdl/tpe_apb_regs.sv -----
// -----------------------------------------------------------------------------
// Tabular page extractor configuration registers
// APB-style register file holding standalone mode and the wanted page.
// -----------------------------------------------------------------------------
module tpe_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tpe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tpe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tpe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output tpe_pkg::cfg_t                   cfg
);
	import tpe_pkg::*;

	logic        standalone_q;
	logic [14:0] wanted_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standalone_q <= 1'b0;
			wanted_q     <= 15'd1;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_STANDALONE:  standalone_q <= pwdata[0];
				REG_WANTED_PAGE: wanted_q     <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_STANDALONE:  prdata = {31'd0, standalone_q};
			REG_WANTED_PAGE: prdata = {17'd0, wanted_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.standalone_mode = standalone_q;
	assign cfg.wanted_page     = wanted_q;

endmodule

// ----- hdl/tpe_parser.sv -----
// -----------------------------------------------------------------------------
// Tabular page extractor parser
// Input register and one-pass block walker producing up to two results a beat.
// -----------------------------------------------------------------------------
`include "tabular_page_extractor_core_assert.svh"

module tpe_parser #(
	parameter int MAX_LINES      = tpe_pkg::MAX_LINES_DEF,
	parameter int MAX_LINE_CHARS = tpe_pkg::MAX_LINE_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tpe_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           start_of_block,
	input  logic           room,
	output tpe_pkg::step_t step
);
	import tpe_pkg::*;

	localparam int LINE_W = $clog2(MAX_LINES + 1);
	localparam int CHAR_W = $clog2(MAX_LINE_CHARS + 1);

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_DIV    = 7'b0000010,
		PH_BID    = 7'b0000100,
		PH_SKIP   = 7'b0001000,
		PH_NPAGES = 7'b0010000,
		PH_LEN    = 7'b0100000,
		PH_CHARS  = 7'b1000000
	} phase_t;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              advance;
	logic              accept;

	phase_t            phase_q, phase_d;
	logic [6:0]        hcount_q, hcount_d;
	logic [7:0]        held_q, held_d;
	logic [14:0]       page_idx_q, page_idx_d;
	logic [14:0]       page_cnt_q, page_cnt_d;
	logic [LINE_W-1:0] line_idx_q, line_idx_d;
	logic [CHAR_W-1:0] chars_q, chars_d;

	logic [15:0]       half;
	logic              wanted;
	logic              len_over;
	logic [1:0]        n_res;
	logic [2:0]        kind0, kind1;
	logic [7:0]        byte0;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			start_s1 <= start_of_block;
		end
	end

	assign half     = {held_q, byte_s1};
	assign wanted   = (page_idx_q == cfg.wanted_page);
	assign len_over = !half[15] && (half[14:0] > 15'(MAX_LINE_CHARS));

	always_comb begin
		phase_d    = phase_q;
		hcount_d   = hcount_q;
		held_d     = held_q;
		page_idx_d = page_idx_q;
		page_cnt_d = page_cnt_q;
		line_idx_d = line_idx_q;
		chars_d    = chars_q;
		n_res      = 2'd0;
		kind0      = K_CHAR;
		kind1      = K_LINE_END;
		byte0      = 8'd0;

		if (start_s1) begin
			phase_d    = PH_DIV;
			hcount_d   = 7'd1;
			held_d     = byte_s1;
			page_idx_d = '0;
			page_cnt_d = '0;
			line_idx_d = '0;
			chars_d    = '0;
		end else begin
			unique case (phase_q)
				PH_DIV, PH_BID, PH_NPAGES, PH_LEN: begin
					if (hcount_q == 7'd0) begin
						held_d   = byte_s1;
						hcount_d = 7'd1;
					end else begin
						hcount_d = 7'd0;
						if (phase_q == PH_DIV) begin
							if (half != 16'hFFFF) begin
								n_res   = 2'd1;
								kind0   = K_BAD_HEADER;
								phase_d = PH_IDLE;
							end else begin
								phase_d = cfg.standalone_mode ? PH_NPAGES : PH_BID;
							end
						end else if (phase_q == PH_BID) begin
							if (half != 16'(BLOCK_ID)) begin
								n_res   = 2'd1;
								kind0   = K_BAD_HEADER;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_SKIP;
							end
						end else if (phase_q == PH_NPAGES) begin
							if (half[15] || half == 16'd0) begin
								page_cnt_d = '0;
								n_res      = 2'd1;
								kind0      = K_DONE;
								phase_d    = PH_IDLE;
							end else begin
								page_cnt_d = half[14:0];
								page_idx_d = 15'd1;
								line_idx_d = '0;
								phase_d    = PH_LEN;
							end
						end else begin
							if (len_over) begin
								n_res   = 2'd1;
								kind0   = K_TOO_LONG;
								phase_d = PH_IDLE;
							end else if (line_idx_q == LINE_W'(MAX_LINES) &&
									half != 16'hFFFF) begin
								n_res   = 2'd1;
								kind0   = K_TOO_MANY;
								phase_d = PH_IDLE;
							end else if (half == 16'hFFFF) begin
								if (page_idx_q >= page_cnt_q) begin
									n_res   = 2'd1;
									kind0   = K_DONE;
									phase_d = PH_IDLE;
								end else begin
									page_idx_d = page_idx_q + 15'd1;
									line_idx_d = '0;
									phase_d    = PH_LEN;
								end
							end else if (half[15]) begin
								n_res   = 2'd1;
								kind0   = K_BAD_LENGTH;
								phase_d = PH_IDLE;
							end else if (half == 16'd0) begin
								if (wanted) begin
									n_res = 2'd1;
									kind0 = K_LINE_END;
								end
								line_idx_d = line_idx_q + LINE_W'(1);
								phase_d    = PH_LEN;
							end else begin
								chars_d = half[CHAR_W-1:0];
								phase_d = PH_CHARS;
							end
						end
					end
				end
				PH_SKIP: begin
					hcount_d = hcount_q + 7'd1;
					if (hcount_d >= 7'(SKIP_BYTES)) begin
						hcount_d = 7'd0;
						phase_d  = PH_NPAGES;
					end
				end
				PH_CHARS: begin
					chars_d = chars_q - CHAR_W'(1);
					if (chars_d == '0) begin
						line_idx_d = line_idx_q + LINE_W'(1);
						phase_d    = PH_LEN;
					end
					if (wanted) begin
						kind0 = K_CHAR;
						byte0 = byte_s1;
						n_res = (chars_d == '0) ? 2'd2 : 2'd1;
					end
				end
				PH_IDLE: ;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hcount_q   <= '0;
			held_q     <= '0;
			page_idx_q <= '0;
			page_cnt_q <= '0;
			line_idx_q <= '0;
			chars_q    <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			hcount_q   <= hcount_d;
			held_q     <= held_d;
			page_idx_q <= page_idx_d;
			page_cnt_q <= page_cnt_d;
			line_idx_q <= line_idx_d;
			chars_q    <= chars_d;
		end
	end

	assign step.count          = advance ? n_res : 2'd0;
	assign step.r0.kind        = kind0;
	assign step.r0.out_byte    = byte0;
	assign step.r0.page_total  = page_cnt_d;
	assign step.r0.last_of_run = (n_res == 2'd1);
	assign step.r1.kind        = kind1;
	assign step.r1.out_byte    = 8'd0;
	assign step.r1.page_total  = page_cnt_d;
	assign step.r1.last_of_run = 1'b1;

	`TPE_ASSERT_IMP(a_line_bound, 1'b1, line_idx_q <= LINE_W'(MAX_LINES), "line index beyond limit")
	`TPE_ASSERT_IMP(a_chars_live, phase_q == PH_CHARS, chars_q != '0, "char phase with no chars")
	`TPE_ASSERT_IMP(a_two_only_char, step.count == 2'd2, kind0 == K_CHAR, "pair without char")

endmodule

// ----- hdl/tpe_result_fifo.sv -----
// -----------------------------------------------------------------------------
// Tabular page extractor result queue
// Small queue: up to two results in a cycle, one out a cycle while not stalled.
// -----------------------------------------------------------------------------
`include "tabular_page_extractor_core_assert.svh"

module tpe_result_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  tpe_pkg::step_t   step,
	output logic             room,
	output logic             out_valid,
	input  logic             out_stall,
	output tpe_pkg::result_t head
);
	import tpe_pkg::*;

	result_t                entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic                   pop;
	logic                   push;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign push      = (step.count != 2'd0);
	assign room      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (step.count != 2'd0) begin
			entries_q[wr_ptr_q] <= step.r0;
		end
		if (step.count == 2'd2) begin
			entries_q[wr_ptr_q + FIFO_PTR_W'(1)] <= step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(step.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(step.count) - FIFO_CNT_W'(pop);
		end
	end

	`TPE_ASSERT_IMP(a_no_overflow, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")
	`TPE_ASSERT_IMP(a_push_room, push, count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2), "push without room")
	`TPE_ASSERT_NXT(a_pop_drain, pop && !push, count_q == $past(count_q) - FIFO_CNT_W'(1), "bad drain")

endmodule

// ----- hdl/tabular_page_extractor_core.sv -----
// -----------------------------------------------------------------------------
// Tabular page extractor core
// Walks a tabular text block byte by byte and emits the lines of one page.
// -----------------------------------------------------------------------------
// The input channel takes one block byte per beat, with start_of_block set on
// the first byte of a block. The output channel gives one result per beat:
// a character, a line end, the finish mark or an error code, with the page
// count from the header and a flag on the last result caused by a byte.
// A byte is held in an input register and walked from there, and its
// results enter a four-entry result queue that offers them at the output.
// One byte is taken per cycle while in_stall is low. The last character of
// a line on the wanted page gives two results, but every line also costs
// two length bytes that give at most one result between them, so a
// receiver that never stalls never holds up the input.
// When the receiver stalls, results collect in the queue and the input
// stalls once fewer than two queue entries are free; nothing is dropped.
// Reset empties the queue and input register, puts the walker in idle, and
// loads standalone mode 0 and wanted page 1. The user configures through the
// APB-style port only while the block is idle; the block does not enforce it.
// -----------------------------------------------------------------------------
module tabular_page_extractor_core #(
	parameter int MAX_LINES      = tpe_pkg::MAX_LINES_DEF,
	parameter int MAX_LINE_CHARS = tpe_pkg::MAX_LINE_CHARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tpe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tpe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tpe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            start_of_block,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      kind,
	output logic [7:0]                      out_byte,
	output logic [14:0]                     page_total,
	output logic                            last_of_run
);
	import tpe_pkg::*;

	cfg_t    cfg;
	step_t   step;
	result_t head;
	logic    room;

	tpe_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpe_parser #(
		.MAX_LINES      (MAX_LINES),
		.MAX_LINE_CHARS (MAX_LINE_CHARS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.start_of_block (start_of_block),
		.room           (room),
		.step           (step)
	);

	tpe_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind        = head.kind;
	assign out_byte    = head.out_byte;
	assign page_total  = head.page_total;
	assign last_of_run = head.last_of_run;

endmodule
